// File: rtl/tgct_pkg.sv
// Shared constants for the tile grid contour tracer.
`timescale 1ns / 1ps
`default_nettype none
package tgct_pkg;
  localparam int MAX_WIDTH = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int LAYERS = 4;
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_BEGIN = 2'd1;
  localparam logic [1:0] KIND_FETCH = 2'd2;
  localparam logic [1:0] HD_UP = 2'd0;
  localparam logic [1:0] HD_RIGHT = 2'd1;
  localparam logic [1:0] HD_DOWN = 2'd2;
  localparam logic [1:0] HD_LEFT = 2'd3;
  localparam logic [1:0] CFG_WIDTH = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_LAYER = 2'd2;
endpackage
`default_nettype wire

// File: rtl/tgct_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
`timescale 1ns / 1ps
`default_nettype none
module tgct_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/tile_grid_contour_tracer.sv
// Top level of the tile grid contour tracer.
// Usage: load occupancy with write items (kind 0), start with a begin item
// (kind 1), then send fetch items (kind 2); each fetch returns one outline
// corner point, first_of_loop on the first point of a loop, done_res when
// no loops remain. A write item returns no result. A begin sweeps the
// whole grid, two cell-store reads per cell.
// A fetch on a running trace works through four serial cell-store reads
// plus a mark write before it shows its result. A fetch that starts a
// loop scans the mark memory one entry per cycle from the start. A fetch
// after done or before any begin shows its result in the cycle after it
// is taken.
// One item is worked at a time; the result sits in an output
// register, and the next item is taken once the result is accepted.
// A stalled receiver holds the result and blocks further input.
// Reset clears control state and the mark memory is cleared by a pass over
// all MAX_WIDTH*MAX_HEIGHT entries after reset, during which no item is taken.
// The configuration port is always ready.
`timescale 1ns / 1ps
`default_nettype none
module tile_grid_contour_tracer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_kind,
  input  wire logic [5:0] in_cell_x,
  input  wire logic [5:0] in_cell_y,
  input  wire logic [1:0] in_cell_layer,
  input  wire logic       in_occupied,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [6:0]      out_corner_x,
  output logic [6:0]      out_corner_y,
  output logic            out_first_of_loop,
  output logic            out_done_res,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [6:0] cfg_data
);
  localparam int MAX_WIDTH = tgct_pkg::MAX_WIDTH;
  localparam int MAX_HEIGHT = tgct_pkg::MAX_HEIGHT;
  localparam int LAYERS = tgct_pkg::LAYERS;
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int LW = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int MD = MAX_WIDTH * MAX_HEIGHT;
  localparam int MA = $clog2(MD);
  localparam int CD = LAYERS * MD;
  localparam int CA = $clog2(CD);
  localparam int CW = XW + 2;
  localparam logic signed [CW:0] SONE = (CW+1)'(1);

  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_OUT = 4'd2,
    S_BRD0 = 4'd3, S_BRD1 = 4'd4, S_BRD2 = 4'd5, S_SCAN = 4'd6,
    S_SCANW = 4'd7, S_TRD = 4'd8, S_TRW = 4'd9, S_SEEKI = 4'd10;

  localparam logic [1:0] P_IDLE = 2'd0, P_SEEK = 2'd1, P_TRACE = 2'd2,
    P_DONE = 2'd3;

  logic [3:0] st_r, st_nxt;
  logic [6:0] gw_r, gh_r;
  logic [1:0] al_r;
  logic [1:0] phase_r;
  logic [XW-1:0] cx_r;
  logic [YW-1:0] cy_r;
  logic [1:0] hd_r;
  logic [6:0] lsx_r, lsy_r;
  logic [MA:0] cnt_r;
  logic [2:0] step_r;
  logic [6:0] ox_r, oy_r;
  logic of_r, od_r, ov_r;
  logic e0_r, e1_r, e2_r, e3_r;

  always_comb cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= 7'd64; gh_r <= 7'd64; al_r <= 2'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tgct_pkg::CFG_WIDTH:  gw_r <= cfg_data;
        tgct_pkg::CFG_HEIGHT: gh_r <= cfg_data;
        tgct_pkg::CFG_LAYER:  al_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic [8:0] ew, eh;
  always_comb begin
    ew = (9'(gw_r) > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : 9'(gw_r);
    eh = (9'(gh_r) > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : 9'(gh_r);
  end

  // cell store read: signed coordinates, out-of-grid flag
  logic signed [CW:0] qx;
  logic signed [CW:0] qy;
  logic q_off_r;
  logic cs_rd;
  logic [CA-1:0] cs_ra;
  logic cs_we;
  logic [CA-1:0] cs_wa;
  logic q_off;
  always_comb begin
    q_off = (qx < 0) || (qy < 0) || (qx >= $signed({1'b0, ew})) ||
            (qy >= $signed({1'b0, eh})) || (32'(al_r) >= LAYERS);
    cs_ra = CA'({al_r, qy[YW-1:0], qx[XW-1:0]});
  end
  logic in_layer_ok;
  always_comb begin
    in_layer_ok = (32'(in_cell_x) < MAX_WIDTH) && (32'(in_cell_y) < MAX_HEIGHT) &&
                  (32'(in_cell_layer) < LAYERS);
    cs_wa = CA'({in_cell_layer[LW-1:0], in_cell_y[YW-1:0], in_cell_x[XW-1:0]});
  end
  tgct_ram #(.WIDTH(1), .DEPTH(CD)) u_cells (
    .clk(clk), .we(cs_we), .waddr(cs_wa), .wdata(in_occupied),
    .raddr(cs_ra), .rdata(cs_rd));
  logic cell_empty;
  always_comb cell_empty = q_off_r || !cs_rd;

  logic mk_we, mk_wd, mk_rd;
  logic [MA-1:0] mk_wa, mk_ra;
  tgct_ram #(.WIDTH(1), .DEPTH(MD)) u_marks (
    .clk(clk), .we(mk_we), .waddr(mk_wa), .wdata(mk_wd),
    .raddr(mk_ra), .rdata(mk_rd));

  logic acc;
  always_comb begin
    in_ready = (st_r == S_IDLE);
    acc = in_valid && in_ready;
    out_valid = ov_r;
    out_corner_x = ox_r; out_corner_y = oy_r;
    out_first_of_loop = of_r; out_done_res = od_r;
    cs_we = acc && (in_kind == tgct_pkg::KIND_WRITE) && in_layer_ok;
  end

  // signed cell coordinates for trace and sweep, and the mark scan address
  logic signed [CW:0] sx, sy;
  logic signed [CW:0] scx, scy;
  logic [MA-1:0] scan_a;
  always_comb begin
    sx = $signed((CW+1)'(cx_r)); sy = $signed((CW+1)'(cy_r));
    scx = $signed((CW+1)'(cnt_r[XW-1:0]));
    scy = $signed((CW+1)'(cnt_r[MA-1:XW]));
    scan_a = cnt_r[MA-1:0];
  end

  logic [6:0] pcx, pcy;
  always_comb begin
    unique case (hd_r)
      tgct_pkg::HD_UP:    begin pcx = 7'(cx_r);        pcy = 7'(cy_r) + 7'd1; end
      tgct_pkg::HD_RIGHT: begin pcx = 7'(cx_r) + 7'd1; pcy = 7'(cy_r) + 7'd1; end
      tgct_pkg::HD_DOWN:  begin pcx = 7'(cx_r) + 7'd1; pcy = 7'(cy_r);        end
      default:            begin pcx = 7'(cx_r);        pcy = 7'(cy_r);        end
    endcase
  end

  // steps: 0 read (x,y), 1 read (x,y+1), 2 read n1, 3 read n2, 4 use
  always_comb begin
    qx = sx; qy = sy;
    mk_ra = scan_a;
    mk_we = 1'b0; mk_wd = 1'b0; mk_wa = scan_a;
    st_nxt = st_r;
    unique case (st_r)
      S_CLR: begin
        mk_we = 1'b1;
        if (cnt_r == (MA+1)'(MD - 1)) st_nxt = S_IDLE;
      end
      S_BRD0: begin qx = scx; qy = scy; end
      S_BRD1: begin qx = scx; qy = scy + SONE; end
      S_BRD2: begin
        qx = scx; qy = scy + SONE;
        mk_we = 1'b1; mk_wd = e0_r && cell_empty;
      end
      S_TRD: begin
        unique case (step_r)
          3'd0: begin qx = sx; qy = sy; end
          3'd1: begin qx = sx; qy = sy + SONE; end
          default: begin
            unique case (hd_r)
              tgct_pkg::HD_UP: begin
                qy = sy + SONE; qx = (step_r == 3'd2) ? sx : sx - SONE;
              end
              tgct_pkg::HD_RIGHT: begin
                qx = sx + SONE; qy = (step_r == 3'd2) ? sy : sy + SONE;
              end
              tgct_pkg::HD_DOWN: begin
                qy = sy - SONE; qx = (step_r == 3'd2) ? sx : sx + SONE;
              end
              default: begin
                qx = sx - SONE; qy = (step_r == 3'd2) ? sy : sy - SONE;
              end
            endcase
          end
        endcase
      end
      S_TRW: begin
        mk_wa = MA'({cy_r, cx_r});
        mk_we = !e0_r && e1_r;
        mk_wd = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    q_off_r <= q_off;
    if (!rst_n) begin
      st_r <= S_CLR; cnt_r <= '0; phase_r <= P_IDLE; ov_r <= 1'b0;
      cx_r <= '0; cy_r <= '0; hd_r <= tgct_pkg::HD_UP;
      lsx_r <= '0; lsy_r <= '0; step_r <= '0;
    end else begin
      unique case (st_r)
        S_CLR: begin
          if (st_nxt == S_IDLE) begin
            cnt_r <= '0; st_r <= S_IDLE;
          end else cnt_r <= cnt_r + 1'b1;
        end
        S_IDLE: if (acc) begin
          unique case (in_kind)
            tgct_pkg::KIND_BEGIN: begin
              st_r <= S_BRD0; cnt_r <= '0; phase_r <= P_SEEK;
            end
            tgct_pkg::KIND_FETCH: begin
              if (phase_r == P_SEEK) begin
                st_r <= S_SEEKI; cnt_r <= '0;
              end else if (phase_r == P_TRACE) begin
                if (pcx == lsx_r && pcy == lsy_r) begin
                  st_r <= S_SEEKI; cnt_r <= '0;
                end else begin
                  ox_r <= pcx; oy_r <= pcy; of_r <= 1'b0; od_r <= 1'b0;
                  st_r <= S_TRD; step_r <= '0;
                end
              end else begin
                ox_r <= '0; oy_r <= '0; of_r <= 1'b0; od_r <= 1'b1;
                ov_r <= 1'b1; st_r <= S_OUT;
              end
            end
            default: ;
          endcase
        end
        S_OUT: if (out_ready) begin ov_r <= 1'b0; st_r <= S_IDLE; end
        S_BRD0: st_r <= S_BRD1;
        S_BRD1: begin e0_r <= !cell_empty; st_r <= S_BRD2; end
        S_BRD2: begin
          cnt_r <= cnt_r + 1'b1;
          st_r <= (cnt_r == (MA+1)'(MD - 1)) ? S_IDLE : S_BRD0;
        end
        S_SEEKI: begin
          cnt_r <= cnt_r + 1'b1;
          st_r <= S_SCAN;
        end
        S_SCAN: begin
          if (mk_rd) begin
            cx_r <= cnt_r[XW-1:0] - XW'(1);
            cy_r <= cnt_r[MA-1:XW];
            hd_r <= tgct_pkg::HD_RIGHT;
            phase_r <= P_TRACE;
            st_r <= S_SCANW;
          end else if (cnt_r == (MA+1)'(MD)) begin
            phase_r <= P_DONE;
            ox_r <= '0; oy_r <= '0; of_r <= 1'b0; od_r <= 1'b1;
            ov_r <= 1'b1; st_r <= S_OUT;
          end else cnt_r <= cnt_r + 1'b1;
        end
        S_SCANW: begin
          // read address ran one ahead; hit was entry cnt_r-1
          cx_r <= XW'(cnt_r - 1'b1);
          cy_r <= YW'((cnt_r - 1'b1) >> XW);
          lsx_r <= 7'(XW'(cnt_r - 1'b1));
          lsy_r <= 7'(YW'((cnt_r - 1'b1) >> XW)) + 7'd1;
          ox_r <= 7'(XW'(cnt_r - 1'b1));
          oy_r <= 7'(YW'((cnt_r - 1'b1) >> XW)) + 7'd1;
          of_r <= 1'b1; od_r <= 1'b0; ov_r <= 1'b1; st_r <= S_OUT;
        end
        S_TRD: begin
          step_r <= step_r + 1'b1;
          if (step_r == 3'd1) e0_r <= cell_empty;
          if (step_r == 3'd2) e1_r <= cell_empty;
          if (step_r == 3'd3) e2_r <= cell_empty;
          if (step_r == 3'd4) begin e3_r <= cell_empty; st_r <= S_TRW; end
        end
        S_TRW: begin
          if (e2_r) hd_r <= hd_r + 2'd1;
          else if (e3_r) begin
            unique case (hd_r)
              tgct_pkg::HD_UP:    cy_r <= cy_r + 1'b1;
              tgct_pkg::HD_RIGHT: cx_r <= cx_r + 1'b1;
              tgct_pkg::HD_DOWN:  cy_r <= cy_r - 1'b1;
              default:            cx_r <= cx_r - 1'b1;
            endcase
          end else begin
            hd_r <= hd_r - 2'd1;
            unique case (hd_r)
              tgct_pkg::HD_UP:    begin cx_r <= cx_r - 1'b1; cy_r <= cy_r + 1'b1; end
              tgct_pkg::HD_RIGHT: begin cx_r <= cx_r + 1'b1; cy_r <= cy_r + 1'b1; end
              tgct_pkg::HD_DOWN:  begin cx_r <= cx_r + 1'b1; cy_r <= cy_r - 1'b1; end
              default:            begin cx_r <= cx_r - 1'b1; cy_r <= cy_r - 1'b1; end
            endcase
          end
          ov_r <= 1'b1; st_r <= S_OUT;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/tgct_checker.sv
// Port-level assertions for the tile grid contour tracer, with bind.
`timescale 1ns / 1ps
`default_nettype none
module tgct_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_first_of_loop,
  input wire logic out_done_res,
  input wire logic [6:0] out_corner_x,
  input wire logic [6:0] out_corner_y
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_corner_x)) else $error("out hold");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("ready while out pending");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> out_corner_x == 7'd0 && out_corner_y == 7'd0
      && !out_first_of_loop) else $error("done fields");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid) else $error("reset");
endmodule
bind tile_grid_contour_tracer tgct_checker u_tgct_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_first_of_loop(out_first_of_loop), .out_done_res(out_done_res),
  .out_corner_x(out_corner_x), .out_corner_y(out_corner_y));
`default_nettype wire

// File: test/tile_grid_contour_tracer_tb.sv
// Self-checking testbench for tile_grid_contour_tracer: directed table, then random phases.
`timescale 1ns / 1ps
module tile_grid_contour_tracer_tb;

  localparam logic [1:0] KIND_IGNORED = 2'd3;
  localparam int GRID_MAX = 64;
  localparam int LONG_HOLD = 400;
  localparam int ITEM_GOAL = 1700;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SEEK = 2'd1,
    PH_TRACE = 2'd2,
    PH_DONE = 2'd3
  } trace_phase_t;

  typedef struct packed {
    logic [6:0] cx;
    logic [6:0] cy;
    logic       first;
    logic       done;
  } corner_t;

  typedef struct {
    logic [1:0] kind;
    logic [5:0] x;
    logic [5:0] y;
    logic [1:0] layer;
    logic       occ;
    bit         typed;
    corner_t    want;
  } stim_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_kind;
  logic [5:0] in_cell_x;
  logic [5:0] in_cell_y;
  logic [1:0] in_cell_layer;
  logic       in_occupied;
  logic       out_valid;
  logic       out_ready;
  logic [6:0] out_corner_x;
  logic [6:0] out_corner_y;
  logic       out_first_of_loop;
  logic       out_done_res;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [6:0] cfg_data;

  tile_grid_contour_tracer dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_kind(in_kind),
    .in_cell_x(in_cell_x),
    .in_cell_y(in_cell_y),
    .in_cell_layer(in_cell_layer),
    .in_occupied(in_occupied),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_corner_x(out_corner_x),
    .out_corner_y(out_corner_y),
    .out_first_of_loop(out_first_of_loop),
    .out_done_res(out_done_res),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // tracer model state
  bit           occupancy[4][GRID_MAX][GRID_MAX];
  bit           loop_marks[GRID_MAX][GRID_MAX];
  int           cur_x;
  int           cur_y;
  logic [1:0]   dir;
  int           origin_x;
  int           origin_y;
  trace_phase_t phase;
  logic [6:0]   grid_w;
  logic [6:0]   grid_h;
  logic [1:0]   layer_sel;

  corner_t pending_corners[$];
  int      error_count;
  int      item_count;
  bit      hold_req;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int dim_of(logic [6:0] v);
    return (v > GRID_MAX) ? GRID_MAX : int'(v);
  endfunction

  function automatic bit is_empty(int x, int y);
    if (x < 0 || y < 0 || x >= dim_of(grid_w) || y >= dim_of(grid_h)) return 1'b1;
    return !occupancy[layer_sel][y][x];
  endfunction

  function automatic corner_t find_loop();
    corner_t r;
    r = '0;
    for (int y = 0; y < GRID_MAX; y++) begin
      for (int x = 0; x < GRID_MAX; x++) begin
        if (loop_marks[y][x]) begin
          cur_x = x;
          cur_y = y;
          origin_x = x;
          origin_y = y + 1;
          dir = tgct_pkg::HD_RIGHT;
          phase = PH_TRACE;
          r.cx = 7'(origin_x);
          r.cy = 7'(origin_y);
          r.first = 1'b1;
          return r;
        end
      end
    end
    phase = PH_DONE;
    r.done = 1'b1;
    return r;
  endfunction

  function automatic void step_walk();
    int x;
    int y;
    x = cur_x;
    y = cur_y;
    case (dir)
      tgct_pkg::HD_UP: begin
        if (is_empty(x, y + 1)) dir = tgct_pkg::HD_RIGHT;
        else if (is_empty(x - 1, y + 1)) cur_y = y + 1;
        else begin
          dir = tgct_pkg::HD_LEFT; cur_x = x - 1; cur_y = y + 1;
        end
      end
      tgct_pkg::HD_RIGHT: begin
        if (is_empty(x + 1, y)) dir = tgct_pkg::HD_DOWN;
        else if (is_empty(x + 1, y + 1)) cur_x = x + 1;
        else begin
          dir = tgct_pkg::HD_UP; cur_x = x + 1; cur_y = y + 1;
        end
      end
      tgct_pkg::HD_DOWN: begin
        if (is_empty(x, y - 1)) dir = tgct_pkg::HD_LEFT;
        else if (is_empty(x + 1, y - 1)) cur_y = y - 1;
        else begin
          dir = tgct_pkg::HD_RIGHT; cur_x = x + 1; cur_y = y - 1;
        end
      end
      default: begin
        if (is_empty(x - 1, y)) dir = tgct_pkg::HD_UP;
        else if (is_empty(x - 1, y - 1)) cur_x = x - 1;
        else begin
          dir = tgct_pkg::HD_DOWN; cur_x = x - 1; cur_y = y - 1;
        end
      end
    endcase
  endfunction

  function automatic corner_t next_corner();
    corner_t r;
    int px;
    int py;
    r = '0;
    if (phase == PH_IDLE || phase == PH_DONE) begin
      r.done = 1'b1;
      return r;
    end
    if (phase == PH_SEEK) return find_loop();
    case (dir)
      tgct_pkg::HD_UP: begin px = cur_x; py = cur_y + 1; end
      tgct_pkg::HD_RIGHT: begin px = cur_x + 1; py = cur_y + 1; end
      tgct_pkg::HD_DOWN: begin px = cur_x + 1; py = cur_y; end
      default: begin px = cur_x; py = cur_y; end
    endcase
    if (px == origin_x && py == origin_y) return find_loop();
    r.cx = 7'(px);
    r.cy = 7'(py);
    if (!is_empty(cur_x, cur_y) && is_empty(cur_x, cur_y + 1) && cur_x >= 0 &&
        cur_x < GRID_MAX && cur_y >= 0 && cur_y < GRID_MAX)
      loop_marks[cur_y][cur_x] = 1'b0;
    step_walk();
    return r;
  endfunction

  function automatic void mark_tops();
    for (int y = 0; y < GRID_MAX; y++)
      for (int x = 0; x < GRID_MAX; x++)
        loop_marks[y][x] = !is_empty(x, y) && is_empty(x, y + 1);
    phase = PH_SEEK;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  task automatic send_item(input stim_row_t row, output corner_t res);
    int gap;
    res = '0;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_kind <= row.kind;
    in_cell_x <= row.x;
    in_cell_y <= row.y;
    in_cell_layer <= row.layer;
    in_occupied <= row.occ;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    case (row.kind)
      tgct_pkg::KIND_WRITE: occupancy[row.layer][row.y][row.x] = row.occ;
      tgct_pkg::KIND_BEGIN: mark_tops();
      tgct_pkg::KIND_FETCH: begin
        res = next_corner();
        pending_corners = {pending_corners, (row.typed ? row.want : res)};
      end
      default: ;
    endcase
    if (row.kind != KIND_IGNORED) item_count++;
  endtask

  task automatic send_simple(input logic [1:0] kind, input int x, input int y, input int l,
                             input bit occ, output corner_t res);
    stim_row_t row;
    row.kind = kind;
    row.x = 6'(x);
    row.y = 6'(y);
    row.layer = 2'(l);
    row.occ = occ;
    row.typed = 1'b0;
    row.want = '0;
    send_item(row, res);
  endtask

  task automatic settle();
    int guard;
    guard = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_corners.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      tgct_pkg::CFG_WIDTH: grid_w = val;
      tgct_pkg::CFG_HEIGHT: grid_h = val;
      tgct_pkg::CFG_LAYER: layer_sel = val[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [6:0] w, input logic [6:0] h, input logic [1:0] l,
                           input bit squeeze);
    corner_t res;
    int density;
    int fetches;
    int r;
    write_reg(tgct_pkg::CFG_WIDTH, w);
    write_reg(tgct_pkg::CFG_HEIGHT, h);
    write_reg(tgct_pkg::CFG_LAYER, l);
    density = $urandom_range(25, 75);
    for (int y = 0; y < dim_of(h); y++)
      for (int x = 0; x < dim_of(w); x++)
        send_simple(tgct_pkg::KIND_WRITE, x, y, l, $urandom_range(0, 99) < density, res);
    send_simple(tgct_pkg::KIND_BEGIN, 0, 0, 0, 0, res);
    if (squeeze) hold_req = 1'b1;
    fetches = 0;
    res = '0;
    while (!res.done && fetches < 300) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        send_simple(tgct_pkg::KIND_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom_range(0, 3), $urandom_range(0, 1), res);
        res = '0;
      end else if (r < 8) begin
        send_simple(KIND_IGNORED, $urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom_range(0, 3), $urandom_range(0, 1), res);
        res = '0;
      end else if (r < 9) begin
        send_simple(tgct_pkg::KIND_BEGIN, 0, 0, 0, 0, res);
        res = '0;
      end else begin
        send_simple(tgct_pkg::KIND_FETCH, 0, 0, 0, 0, res);
        fetches++;
      end
    end
    send_simple(tgct_pkg::KIND_FETCH, 0, 0, 0, 0, res);
    settle();
  endtask

  // receiver: random stalls, plus one long hold on request
  initial begin
    int stall;
    int r;
    stall = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) out_ready <= 1'b1;
        else begin
          out_ready <= 1'b0;
          stall = (r < 96) ? $urandom_range(0, 2) : $urandom_range(20, 60);
        end
      end
    end
  end

  always @(posedge clk) begin
    corner_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_corners.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d first=%0b done=%0b", $time,
                 out_corner_x, out_corner_y, out_first_of_loop, out_done_res);
        error_count++;
      end else begin
        want = pending_corners.pop_front();
        if (out_corner_x !== want.cx) begin
          $display("%0t: corner_x expected %0d got %0d", $time, want.cx, out_corner_x);
          error_count++;
        end
        if (out_corner_y !== want.cy) begin
          $display("%0t: corner_y expected %0d got %0d", $time, want.cy, out_corner_y);
          error_count++;
        end
        if (out_first_of_loop !== want.first) begin
          $display("%0t: first_of_loop expected %0b got %0b", $time, want.first,
                   out_first_of_loop);
          error_count++;
        end
        if (out_done_res !== want.done) begin
          $display("%0t: done_res expected %0b got %0b", $time, want.done, out_done_res);
          error_count++;
        end
      end
    end
  end

  initial begin
    #500ms;
    $display("tile_grid_contour_tracer_tb: errors");
    $finish;
  end

  initial begin
    stim_row_t table_rows[$];
    stim_row_t row;
    corner_t res;
    corner_t done_val;
    corner_t start_val;
    int guard;
    logic [6:0] w;
    logic [6:0] h;

    error_count = 0;
    item_count = 0;
    hold_req = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = tgct_pkg::KIND_WRITE;
    in_cell_x = '0;
    in_cell_y = '0;
    in_cell_layer = '0;
    in_occupied = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = tgct_pkg::CFG_WIDTH;
    cfg_data = '0;
    grid_w = 7'd64;
    grid_h = 7'd64;
    layer_sel = 2'd0;
    phase = PH_IDLE;
    dir = tgct_pkg::HD_UP;
    cur_x = 0;
    cur_y = 0;
    origin_x = 0;
    origin_y = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    done_val = '0;
    done_val.done = 1'b1;
    start_val = '0;
    start_val.cx = 7'd0;
    start_val.cy = 7'd1;
    start_val.first = 1'b1;

    // directed: fetch before begin, ignored kind, then a two-cell strip on layer 3
    table_rows = '{
      '{tgct_pkg::KIND_FETCH, 6'd0, 6'd0, 2'd0, 1'b0, 1'b1, done_val},
      '{KIND_IGNORED, 6'd63, 6'd63, 2'd3, 1'b1, 1'b0, '0},
      '{tgct_pkg::KIND_FETCH, 6'd0, 6'd0, 2'd0, 1'b0, 1'b1, done_val}
    };
    foreach (table_rows[i]) send_item(table_rows[i], res);
    settle();
    write_reg(tgct_pkg::CFG_WIDTH, 7'd2);
    write_reg(tgct_pkg::CFG_HEIGHT, 7'd1);
    write_reg(tgct_pkg::CFG_LAYER, 2'd3);
    table_rows = '{
      '{tgct_pkg::KIND_WRITE, 6'd0, 6'd0, 2'd3, 1'b1, 1'b0, '0},
      '{tgct_pkg::KIND_WRITE, 6'd1, 6'd0, 2'd3, 1'b1, 1'b0, '0},
      '{tgct_pkg::KIND_WRITE, 6'd63, 6'd63, 2'd3, 1'b0, 1'b0, '0},
      '{tgct_pkg::KIND_BEGIN, 6'd0, 6'd0, 2'd0, 1'b0, 1'b0, '0},
      '{tgct_pkg::KIND_FETCH, 6'd0, 6'd0, 2'd0, 1'b0, 1'b1, start_val},
      '{tgct_pkg::KIND_FETCH, 6'd0, 6'd0, 2'd0, 1'b0, 1'b0, '0},
      '{tgct_pkg::KIND_FETCH, 6'd0, 6'd0, 2'd0, 1'b0, 1'b0, '0},
      '{tgct_pkg::KIND_FETCH, 6'd0, 6'd0, 2'd0, 1'b0, 1'b0, '0},
      '{tgct_pkg::KIND_FETCH, 6'd0, 6'd0, 2'd0, 1'b0, 1'b0, '0},
      '{tgct_pkg::KIND_FETCH, 6'd0, 6'd0, 2'd0, 1'b0, 1'b0, '0},
      '{tgct_pkg::KIND_FETCH, 6'd0, 6'd0, 2'd0, 1'b0, 1'b0, '0},
      '{tgct_pkg::KIND_BEGIN, 6'd0, 6'd0, 2'd0, 1'b0, 1'b0, '0},
      '{tgct_pkg::KIND_FETCH, 6'd0, 6'd0, 2'd0, 1'b0, 1'b1, start_val},
      '{tgct_pkg::KIND_FETCH, 6'd0, 6'd0, 2'd0, 1'b0, 1'b0, '0}
    };
    foreach (table_rows[i]) send_item(table_rows[i], res);
    settle();

    // extremes of the grid registers, then random settings
    run_phase(7'd127, 7'd1, 2'd1, 1'b0);
    run_phase(7'd1, 7'd64, 2'd2, 1'b1);
    run_phase(7'd0, 7'd5, 2'd0, 1'b0);
    run_phase(7'd3, 7'd0, 2'd3, 1'b0);
    run_phase(7'd2, 7'd127, 2'd0, 1'b0);
    run_phase(7'd64, 7'd2, 2'd3, 1'b0);
    while (item_count < ITEM_GOAL) begin
      w = $urandom_range(0, 99) < 10 ? 7'($urandom_range(1, 127)) : 7'($urandom_range(1, 10));
      h = 7'($urandom_range(1, 10));
      if (32'(w) * 32'(h) > 600) h = 7'd1;
      run_phase(w, h, 2'($urandom_range(0, 3)), 1'b0);
    end

    guard = 0;
    while (pending_corners.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (50) @(negedge clk);
    if (error_count == 0 && pending_corners.size() == 0) begin
      $display("tile_grid_contour_tracer_tb: clean");
    end else begin
      $display("tile_grid_contour_tracer_tb: errors");
    end
    $finish;
  end
endmodule
